FILE: rtl/hps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg: shared definitions for the haptic pattern sequencer
// Command and status codes, widths and the fixed segment tables of the
// seven vibration patterns.
// ----------------------------------------------------------------------------
package hps_pkg;

   // Width of the free-running millisecond time base and of the end stamp.
   localparam int TIME_WIDTH = 32;

   localparam int FUNC_WIDTH   = 3;
   localparam int PID_WIDTH    = 3;
   localparam int PULSE_WIDTH  = 16;
   localparam int LEVEL_WIDTH  = 7;
   localparam int STATUS_WIDTH = 2;
   localparam int MS_WIDTH     = 10;
   localparam int SEG_WIDTH    = 8;
   localparam int SEGIDX_WIDTH = 3;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [PID_WIDTH-1:0] NUM_PATTERNS = 3'd7;

   // Input command codes.
   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PLAY  = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PULSE = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_LEVEL = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STOP  = 3'd4;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_INIT  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DEBOUNCED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_PULSE = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_PULSE = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GAP       = 3'd3;

   // Configuration reset values.
   localparam logic [MS_WIDTH-1:0] MIN_PULSE_RESET = 10'd30;
   localparam logic [MS_WIDTH-1:0] MAX_PULSE_RESET = 10'd500;
   localparam logic [MS_WIDTH-1:0] GAP_RESET       = 10'd150;

   // One result word.
   typedef struct packed {
      logic                    motor_on;
      logic [STATUS_WIDTH-1:0] status;
      logic                    pattern_busy;
   } result_type;

   // Number of segments in each pattern; unknown ids have none.
   function automatic logic [SEGIDX_WIDTH-1:0] seg_count(input logic [PID_WIDTH-1:0] pid);
      logic [SEGIDX_WIDTH-1:0] cnt;
      unique case (pid)
         3'd0:    cnt = 3'd1;
         3'd1:    cnt = 3'd1;
         3'd2:    cnt = 3'd3;
         3'd3:    cnt = 3'd5;
         3'd4:    cnt = 3'd7;
         3'd5:    cnt = 3'd1;
         3'd6:    cnt = 3'd3;
         default: cnt = 3'd0;
      endcase
      return cnt;
   endfunction

   // Length in milliseconds of one segment of a pattern.
   function automatic logic [SEG_WIDTH-1:0] seg_len(input logic [PID_WIDTH-1:0] pid,
                                                    input logic [SEGIDX_WIDTH-1:0] idx);
      logic [SEG_WIDTH-1:0] len;
      len = 8'd0;
      unique case (pid)
         3'd0: len = (idx == 3'd0) ? 8'd80 : 8'd0;
         3'd1: len = (idx == 3'd0) ? 8'd200 : 8'd0;
         3'd2: begin
            if (idx == 3'd0 || idx == 3'd2) len = 8'd80;
            else if (idx == 3'd1)           len = 8'd60;
         end
         3'd3: begin
            if (idx == 3'd0 || idx == 3'd2 || idx == 3'd4) len = 8'd50;
            else if (idx == 3'd1 || idx == 3'd3)           len = 8'd40;
         end
         3'd4: begin
            if (idx == 3'd6)       len = 8'd150;
            else if (idx[0])       len = 8'd30;
            else                   len = 8'd20;
         end
         3'd5: len = (idx == 3'd0) ? 8'd120 : 8'd0;
         3'd6: begin
            if (idx == 3'd0)      len = 8'd150;
            else if (idx == 3'd1) len = 8'd50;
            else if (idx == 3'd2) len = 8'd100;
         end
         default: len = 8'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/haptic_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer_core: vibration motor pattern sequencer
// Combinational update of motor, pattern and pulse state from one word.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one word per millisecond tick or command (play,
// pulse, set level, stop). Every accepted word yields exactly one rsp_ word
// with the motor on flag, a status code and the pattern busy flag as they
// stand after that word.
// The whole update is one pass of logic between the state registers and the
// result register, so a word is accepted in every cycle that req_ready is
// high. Sustained throughput is one word per cycle with no receiver stall.
// A result register plus one skid register part the two sides: when the
// receiver stalls, one more word is still taken into the skid register, and
// only then does req_ready drop until the receiver drains.
// The csr_ port writes enable, minimum pulse, maximum pulse and pattern gap
// with no wait; write it only while no words are in flight.
// Synchronous reset clears all state, turns the motor off, disables the
// block and loads the default limits of 30, 500 and 150 ms.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   // Input command channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hps_pkg::FUNC_WIDTH-1:0]    req_func,
   input  logic [hps_pkg::PID_WIDTH-1:0]     req_pattern_id,
   input  logic [hps_pkg::PULSE_WIDTH-1:0]   req_pulse_ms,
   input  logic [hps_pkg::LEVEL_WIDTH-1:0]   req_level_pct,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_motor_on,
   output logic [hps_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                              rsp_pattern_busy,
   // Configuration write port.
   input  logic                              csr_wr_en,
   input  logic [hps_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [hps_pkg::MS_WIDTH-1:0]      csr_wdata
);
   import hps_pkg::*;

   // Configuration registers.
   logic                enable_ff;
   logic [MS_WIDTH-1:0] min_pulse_ff;
   logic [MS_WIDTH-1:0] max_pulse_ff;
   logic [MS_WIDTH-1:0] gap_ff;

   // Sequencer state.
   logic [TIME_WIDTH-1:0]   time_now_ff,   time_now_in;
   logic [TIME_WIDTH-1:0]   last_end_ff,   last_end_in;
   logic                    active_ff,     active_in;
   logic [PID_WIDTH-1:0]    pattern_ff,    pattern_in;
   logic [SEGIDX_WIDTH-1:0] seg_idx_ff,    seg_idx_in;
   logic [SEG_WIDTH-1:0]    seg_left_ff,   seg_left_in;
   logic [MS_WIDTH-1:0]     pulse_left_ff, pulse_left_in;
   logic                    motor_ff,      motor_in;
   logic [STATUS_WIDTH-1:0] status_in;

   // Output and skid registers.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;
   result_type result_in;

   logic accept;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         min_pulse_ff <= MIN_PULSE_RESET;
         max_pulse_ff <= MAX_PULSE_RESET;
         gap_ff       <= GAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_MIN_PULSE: min_pulse_ff <= csr_wdata;
            CSR_MAX_PULSE: max_pulse_ff <= csr_wdata;
            CSR_GAP:       gap_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Next-state logic for one word.
   always_comb begin
      logic [MS_WIDTH-1:0]     pulse_dec;
      logic [SEG_WIDTH-1:0]    seg_dec;
      logic [SEGIDX_WIDTH-1:0] idx_next;
      logic [TIME_WIDTH-1:0]   since_end;
      logic [PULSE_WIDTH-1:0]  dur;

      time_now_in   = time_now_ff;
      last_end_in   = last_end_ff;
      active_in     = active_ff;
      pattern_in    = pattern_ff;
      seg_idx_in    = seg_idx_ff;
      seg_left_in   = seg_left_ff;
      pulse_left_in = pulse_left_ff;
      motor_in      = motor_ff;
      status_in     = STATUS_OK;

      pulse_dec = pulse_left_ff - 1'b1;
      seg_dec   = (seg_left_ff != '0) ? seg_left_ff - 1'b1 : '0;
      idx_next  = seg_idx_ff + 1'b1;
      since_end = time_now_ff - last_end_ff;
      dur       = req_pulse_ms;

      if (req_func == FUNC_TICK) begin
         time_now_in = time_now_ff + 1'b1;
         // One-shot pulse countdown.
         if (pulse_left_ff != '0) begin
            pulse_left_in = pulse_dec;
            if (pulse_dec == '0) begin
               motor_in = 1'b0;
            end
         end
         // Pattern segment countdown; it acts after the pulse.
         if (active_ff) begin
            seg_left_in = seg_dec;
            if (seg_dec == '0) begin
               seg_idx_in = idx_next;
               if (pattern_ff < NUM_PATTERNS && idx_next < seg_count(pattern_ff)) begin
                  motor_in    = !idx_next[0];
                  seg_left_in = seg_len(pattern_ff, idx_next);
               end else begin
                  motor_in    = 1'b0;
                  last_end_in = time_now_in;
                  active_in   = 1'b0;
                  seg_left_in = '0;
               end
            end
         end
      end else if (req_func <= FUNC_STOP && !enable_ff) begin
         status_in = STATUS_NOT_INIT;
      end else if (req_func == FUNC_PLAY) begin
         if (since_end < TIME_WIDTH'(gap_ff)) begin
            status_in = STATUS_DEBOUNCED;
         end else begin
            // Any running pattern is aborted at once, stamping its end.
            if (active_ff) begin
               last_end_in = time_now_ff;
            end
            pattern_in = req_pattern_id;
            seg_idx_in = '0;
            if (req_pattern_id < NUM_PATTERNS) begin
               active_in   = 1'b1;
               motor_in    = 1'b1;
               seg_left_in = seg_len(req_pattern_id, '0);
            end else begin
               // A pattern with no segments ends as soon as it starts.
               active_in   = 1'b0;
               motor_in    = 1'b0;
               seg_left_in = '0;
               last_end_in = time_now_ff;
            end
         end
      end else if (req_func == FUNC_PULSE) begin
         // Raise to the minimum first, then lower to the maximum.
         if (dur < PULSE_WIDTH'(min_pulse_ff)) begin
            dur = PULSE_WIDTH'(min_pulse_ff);
         end
         if (dur > PULSE_WIDTH'(max_pulse_ff)) begin
            dur = PULSE_WIDTH'(max_pulse_ff);
         end
         motor_in      = (dur != '0);
         pulse_left_in = dur[MS_WIDTH-1:0];
      end else if (req_func == FUNC_LEVEL) begin
         motor_in = (req_level_pct != '0);
      end else if (req_func == FUNC_STOP) begin
         pulse_left_in = '0;
         if (active_ff) begin
            last_end_in = time_now_ff;
            active_in   = 1'b0;
            seg_left_in = '0;
         end
         motor_in = 1'b0;
      end

      result_in.motor_on     = motor_in;
      result_in.status       = status_in;
      result_in.pattern_busy = active_in;
   end

   // State registers advance on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff   <= '0;
         last_end_ff   <= '0;
         active_ff     <= 1'b0;
         pattern_ff    <= '0;
         seg_idx_ff    <= '0;
         seg_left_ff   <= '0;
         pulse_left_ff <= '0;
         motor_ff      <= 1'b0;
      end else if (accept) begin
         time_now_ff   <= time_now_in;
         last_end_ff   <= last_end_in;
         active_ff     <= active_in;
         pattern_ff    <= pattern_in;
         seg_idx_ff    <= seg_idx_in;
         seg_left_ff   <= seg_left_in;
         pulse_left_ff <= pulse_left_in;
         motor_ff      <= motor_in;
      end
   end

   // Result register with a one-word skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (accept) begin
            rsp_data_ff <= result_in;
         end
      end else if (accept) begin
         skid_data_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_on     = rsp_data_ff.motor_on;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_pattern_busy = rsp_data_ff.pattern_busy;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the haptic pattern sequencer core
// Drives tick and command words through the req_ channel under random
// gaps and receiver stalls. A behavioral model of the motor, pattern and
// pulse state predicts each rsp_ word, and a monitor compares every
// returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import hps_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // Command codes the block does not decode; they must be ignored.
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_LAST  = 3'd7;

   // Pattern identifiers; the last one has no segments at all.
   localparam logic [PID_WIDTH-1:0] PAT_SHORT  = 3'd0;
   localparam logic [PID_WIDTH-1:0] PAT_LONG   = 3'd1;
   localparam logic [PID_WIDTH-1:0] PAT_DOUBLE = 3'd2;
   localparam logic [PID_WIDTH-1:0] PAT_TRIPLE = 3'd3;
   localparam logic [PID_WIDTH-1:0] PAT_RAMP   = 3'd4;
   localparam logic [PID_WIDTH-1:0] PAT_MILD   = 3'd5;
   localparam logic [PID_WIDTH-1:0] PAT_STRONG = 3'd6;
   localparam logic [PID_WIDTH-1:0] PAT_NONE   = 3'd7;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = 7'd127;
   localparam logic [MS_WIDTH-1:0]    MS_MAX    = 10'd1023;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [FUNC_WIDTH-1:0]    req_func;
   logic [PID_WIDTH-1:0]     req_pattern_id;
   logic [PULSE_WIDTH-1:0]   req_pulse_ms;
   logic [LEVEL_WIDTH-1:0]   req_level_pct;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_motor_on;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic                     rsp_pattern_busy;
   logic                     csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [MS_WIDTH-1:0]      csr_wdata;

   // Set for the closing stretch, where neither side idles.
   bit calm;
   int mismatches;
   int idle_cycles;

   // Predicted result words, oldest first.
   result_type pending_motor_q[$];

   // Model copy of the block state and its registers.
   logic [TIME_WIDTH-1:0]   ms_now;
   logic [TIME_WIDTH-1:0]   ms_last_end;
   logic                    busy_m;
   logic [PID_WIDTH-1:0]    pat_m;
   logic [SEGIDX_WIDTH-1:0] seg_m;
   logic [SEG_WIDTH-1:0]    seg_left_m;
   logic [MS_WIDTH-1:0]     pulse_left_m;
   logic                    motor_m;
   logic                    en_cfg;
   logic [MS_WIDTH-1:0]     min_cfg;
   logic [MS_WIDTH-1:0]     max_cfg;
   logic [MS_WIDTH-1:0]     gap_cfg;

   haptic_pattern_sequencer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_pattern_id   (req_pattern_id),
      .req_pulse_ms     (req_pulse_ms),
      .req_level_pct    (req_level_pct),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motor_on     (rsp_motor_on),
      .rsp_status       (rsp_status),
      .rsp_pattern_busy (rsp_pattern_busy),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Segment count and lengths of each pattern; segment 0 sits in the low byte.
   function automatic void pattern_shape(input logic [PID_WIDTH-1:0] pid,
                                         output logic [SEGIDX_WIDTH-1:0] nseg,
                                         output logic [7*SEG_WIDTH-1:0] lens);
      nseg = '0;
      lens = '0;
      case (pid)
         PAT_SHORT: begin
            nseg = 3'd1;
            lens[SEG_WIDTH-1:0] = 8'd80;
         end
         PAT_LONG: begin
            nseg = 3'd1;
            lens[SEG_WIDTH-1:0] = 8'd200;
         end
         PAT_DOUBLE: begin
            nseg = 3'd3;
            lens[3*SEG_WIDTH-1:0] = {8'd80, 8'd60, 8'd80};
         end
         PAT_TRIPLE: begin
            nseg = 3'd5;
            lens[5*SEG_WIDTH-1:0] = {8'd50, 8'd40, 8'd50, 8'd40, 8'd50};
         end
         PAT_RAMP: begin
            nseg = 3'd7;
            lens = {8'd150, 8'd30, 8'd20, 8'd30, 8'd20, 8'd30, 8'd20};
         end
         PAT_MILD: begin
            nseg = 3'd1;
            lens[SEG_WIDTH-1:0] = 8'd120;
         end
         PAT_STRONG: begin
            nseg = 3'd3;
            lens[3*SEG_WIDTH-1:0] = {8'd100, 8'd50, 8'd150};
         end
         default: ;
      endcase
   endfunction

   function automatic void finish_pattern();
      motor_m     = 1'b0;
      ms_last_end = ms_now;
      busy_m      = 1'b0;
      seg_left_m  = '0;
   endfunction

   // Start the current segment, or end the pattern when none is left.
   function automatic void enter_segment();
      logic [SEGIDX_WIDTH-1:0] nseg;
      logic [7*SEG_WIDTH-1:0]  lens;
      pattern_shape(pat_m, nseg, lens);
      if (seg_m >= nseg) begin
         finish_pattern();
      end else begin
         motor_m    = ~seg_m[0];
         seg_left_m = lens[seg_m*SEG_WIDTH +: SEG_WIDTH];
      end
   endfunction

   // Apply one word to the model state and return the word the block owes.
   function automatic result_type predict_motor_word(input logic [FUNC_WIDTH-1:0] f,
                                                     input logic [PID_WIDTH-1:0] pid,
                                                     input logic [PULSE_WIDTH-1:0] pulse,
                                                     input logic [LEVEL_WIDTH-1:0] lvl);
      logic [STATUS_WIDTH-1:0] st;
      logic [TIME_WIDTH-1:0]   since;
      logic [PULSE_WIDTH-1:0]  len;
      result_type              r;
      st = STATUS_OK;
      if (f == FUNC_TICK) begin
         ms_now = ms_now + 1'b1;
         // The pulse runs first, so a segment boundary on the same tick wins.
         if (pulse_left_m != '0) begin
            pulse_left_m = pulse_left_m - 1'b1;
            if (pulse_left_m == '0) motor_m = 1'b0;
         end
         if (busy_m) begin
            if (seg_left_m != '0) seg_left_m = seg_left_m - 1'b1;
            if (seg_left_m == '0) begin
               seg_m = seg_m + 1'b1;
               enter_segment();
            end
         end
      end else if (f <= FUNC_STOP && !en_cfg) begin
         st = STATUS_NOT_INIT;
      end else begin
         case (f)
            FUNC_PLAY: begin
               since = ms_now - ms_last_end;
               if (since < TIME_WIDTH'(gap_cfg)) begin
                  st = STATUS_DEBOUNCED;
               end else begin
                  if (busy_m) finish_pattern();
                  pat_m  = pid;
                  seg_m  = '0;
                  busy_m = 1'b1;
                  enter_segment();
               end
            end
            FUNC_PULSE: begin
               // Raise to the minimum first, then cap at the maximum.
               len = pulse;
               if (len < PULSE_WIDTH'(min_cfg)) len = PULSE_WIDTH'(min_cfg);
               if (len > PULSE_WIDTH'(max_cfg)) len = PULSE_WIDTH'(max_cfg);
               motor_m      = (len != '0);
               pulse_left_m = len[MS_WIDTH-1:0];
            end
            FUNC_LEVEL: motor_m = (lvl != '0);
            FUNC_STOP: begin
               pulse_left_m = '0;
               if (busy_m) finish_pattern();
               motor_m = 1'b0;
            end
            default: ;
         endcase
      end
      r.motor_on     = motor_m;
      r.status       = st;
      r.pattern_busy = busy_m;
      return r;
   endfunction

   task automatic reset_model();
      ms_now       = '0;
      ms_last_end  = '0;
      busy_m       = 1'b0;
      pat_m        = '0;
      seg_m        = '0;
      seg_left_m   = '0;
      pulse_left_m = '0;
      motor_m      = 1'b0;
      en_cfg       = 1'b0;
      min_cfg      = MIN_PULSE_RESET;
      max_cfg      = MAX_PULSE_RESET;
      gap_cfg      = GAP_RESET;
   endtask

   // Send one word; the sender may idle for a burst before raising valid.
   task automatic send_word(input logic [FUNC_WIDTH-1:0] f,
                            input logic [PID_WIDTH-1:0] pid,
                            input logic [PULSE_WIDTH-1:0] pulse,
                            input logic [LEVEL_WIDTH-1:0] lvl);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_pattern_id <= pid;
      req_pulse_ms   <= pulse;
      req_level_pct  <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_motor_q.push_back(predict_motor_word(f, pid, pulse, lvl));
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_motor_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [MS_WIDTH-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ENABLE:    en_cfg  = data[0];
         CSR_MIN_PULSE: min_cfg = data;
         CSR_MAX_PULSE: max_cfg = data;
         CSR_GAP:       gap_cfg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [MS_WIDTH-1:0] min_ms,
                             input logic [MS_WIDTH-1:0] max_ms,
                             input logic [MS_WIDTH-1:0] gap_ms);
      drain_results();
      write_reg(CSR_ENABLE, MS_WIDTH'(en));
      write_reg(CSR_MIN_PULSE, min_ms);
      write_reg(CSR_MAX_PULSE, max_ms);
      write_reg(CSR_GAP, gap_ms);
   endtask

   // Ticks carry random payload so the unused fields toggle as well.
   task automatic send_tick();
      send_word(FUNC_TICK, PID_WIDTH'($urandom_range(0, PAT_NONE)), PULSE_WIDTH'($urandom),
                LEVEL_WIDTH'($urandom_range(0, LEVEL_MAX)));
   endtask

   task automatic send_random_command();
      int                     pick;
      logic [PID_WIDTH-1:0]   pid;
      logic [PULSE_WIDTH-1:0] pulse;
      logic [LEVEL_WIDTH-1:0] lvl;
      pick  = $urandom_range(0, 99);
      pid   = ($urandom_range(0, 15) == 0) ? PAT_NONE
                                           : PID_WIDTH'($urandom_range(0, PAT_STRONG));
      pulse = ($urandom_range(0, 1) == 0) ? PULSE_WIDTH'($urandom)
                                          : PULSE_WIDTH'($urandom_range(0, 1100));
      lvl   = ($urandom_range(0, 3) == 0) ? '0 : LEVEL_WIDTH'($urandom_range(0, LEVEL_MAX));
      if (pick < 40)      send_word(FUNC_PLAY, pid, pulse, lvl);
      else if (pick < 65) send_word(FUNC_PULSE, pid, pulse, lvl);
      else if (pick < 85) send_word(FUNC_LEVEL, pid, pulse, lvl);
      else if (pick < 95) send_word(FUNC_STOP, pid, pulse, lvl);
      else send_word(FUNC_WIDTH'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                     pid, pulse, lvl);
   endtask

   // A command followed by a run of ticks: mostly short runs, sometimes
   // long enough for segments and whole patterns to play out.
   task automatic run_words(input int count);
      int sent;
      int run;
      sent = 0;
      while (sent < count) begin
         send_random_command();
         sent++;
         run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 250);
         for (int k = 0; k < run && sent < count; k++) begin
            send_tick();
            sent++;
         end
      end
   endtask

   // Commands after reset, while the block is still disabled.
   task automatic test_disabled_commands();
      send_word(FUNC_PLAY, PAT_SHORT, 16'd100, 7'd50);
      send_word(FUNC_PULSE, PAT_LONG, 16'd100, 7'd50);
      send_word(FUNC_LEVEL, PAT_DOUBLE, 16'd0, LEVEL_MAX);
      send_word(FUNC_STOP, PAT_TRIPLE, 16'hFFFF, 7'd1);
      send_word(FUNC_TICK, PAT_NONE, 16'h0000, 7'd0);
      send_word(FUNC_SPARE_FIRST, PAT_RAMP, 16'd5, 7'd5);
   endtask

   // Every operation at least once, the empty pattern, replacement and unknown codes.
   task automatic test_directed_commands();
      set_config(1'b1, MIN_PULSE_RESET, MAX_PULSE_RESET, '0);
      send_word(FUNC_PLAY, PAT_NONE, '0, '0);
      send_word(FUNC_PLAY, PAT_RAMP, '0, '0);
      send_word(FUNC_PULSE, PAT_SHORT, 16'd0, '0);
      send_word(FUNC_LEVEL, PAT_SHORT, '0, 7'd0);
      send_word(FUNC_TICK, PAT_SHORT, '0, '0);
      send_word(FUNC_LEVEL, PAT_SHORT, '0, LEVEL_MAX);
      send_word(FUNC_PLAY, PAT_STRONG, '0, '0);
      send_word(FUNC_STOP, PAT_SHORT, '0, '0);
      send_word(FUNC_PULSE, PAT_SHORT, 16'hFFFF, '0);
      send_word(FUNC_SPARE_FIRST, PAT_SHORT, '0, '0);
      send_word(FUNC_SPARE_FIRST + 3'd1, PAT_SHORT, '0, '0);
      send_word(FUNC_SPARE_LAST, PAT_SHORT, '0, '0);
      send_word(FUNC_STOP, PAT_SHORT, '0, '0);
   endtask

   // A pulse expiring inside a pattern, a debounced play, a clamp to zero.
   task automatic test_pulse_limits();
      set_config(1'b1, 10'd1, 10'd1, '0);
      send_word(FUNC_PLAY, PAT_SHORT, '0, '0);
      send_word(FUNC_PULSE, PAT_SHORT, 16'd7, '0);
      send_word(FUNC_TICK, PAT_SHORT, '0, '0);
      send_word(FUNC_STOP, PAT_SHORT, '0, '0);
      set_config(1'b1, '0, '0, MS_MAX);
      send_word(FUNC_PLAY, PAT_TRIPLE, '0, '0);
      send_word(FUNC_PULSE, PAT_SHORT, 16'd40, '0);
   endtask

   task automatic test_default_traffic();
      set_config(1'b1, MIN_PULSE_RESET, MAX_PULSE_RESET, GAP_RESET);
      run_words(350);
   endtask

   task automatic test_wide_limits();
      set_config(1'b1, 10'd1, MS_MAX, '0);
      run_words(300);
   endtask

   // Minimum above maximum: the maximum must win.
   task automatic test_inverted_limits();
      set_config(1'b1, MS_MAX, 10'd1, MS_MAX);
      run_words(250);
   endtask

   task automatic test_disabled_traffic();
      set_config(1'b0, MS_WIDTH'($urandom_range(1, MS_MAX)),
                 MS_WIDTH'($urandom_range(1, MS_MAX)), MS_WIDTH'($urandom_range(0, MS_MAX)));
      run_words(100);
   endtask

   task automatic test_random_limits();
      set_config(1'b1, MS_WIDTH'($urandom_range(1, MS_MAX)),
                 MS_WIDTH'($urandom_range(1, MS_MAX)), MS_WIDTH'($urandom_range(0, 300)));
      run_words(250);
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_steady_stream();
      set_config(1'b1, MS_WIDTH'($urandom_range(1, 100)),
                 MS_WIDTH'($urandom_range(50, 600)), MS_WIDTH'($urandom_range(0, 200)));
      calm = 1'b1;
      run_words(300);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_TICK;
      req_pattern_id = PAT_SHORT;
      req_pulse_ms   = '0;
      req_level_pct  = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_ENABLE;
      csr_wdata      = '0;
      calm           = 1'b0;
      mismatches     = 0;
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled_commands();
      test_directed_commands();
      test_pulse_limits();
      test_default_traffic();
      test_wide_limits();
      test_inverted_limits();
      test_disabled_traffic();
      test_random_limits();
      test_steady_stream();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_motor_q.size() == 0) begin
         $display("[haptic_pattern_sequencer_core] OK");
      end else begin
         $display("[haptic_pattern_sequencer_core] ERROR");
      end
      $finish;
   end

   // Receiver: random stall bursts, none in the closing stretch.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each returned word with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_motor_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result word with none expected: motor %0b status %0d busy %0b",
                        $realtime, rsp_motor_on, rsp_status, rsp_pattern_busy);
         end else begin
            want = pending_motor_q.pop_front();
            if (rsp_motor_on !== want.motor_on || rsp_status !== want.status ||
                rsp_pattern_busy !== want.pattern_busy) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: mismatch: motor %0b/%0b status %0d/%0d busy %0b/%0b (exp/got)",
                           $realtime, want.motor_on, rsp_motor_on, want.status, rsp_status,
                           want.pattern_busy, rsp_pattern_busy);
            end
         end
      end
   end

   // End the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[haptic_pattern_sequencer_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
